@@ design/inductor_frame_filter_trend_core_assert.svh @@
// Assertion macros for the inductor frame filter checker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef INDUCTOR_FRAME_FILTER_TREND_CORE_ASSERT_SVH
`define INDUCTOR_FRAME_FILTER_TREND_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IFFT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ifft assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IFFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ifft assertion failed");

`endif

@@ design/ifft_pkg.sv @@
// Package for the inductor frame filter: payload types, controller types and constants.
// Used by every module of the block; depends on nothing.
package ifft_pkg;

    localparam int NUM_CH         = 5;
    localparam int CH_W           = 3;
    localparam int SAMPLE_W       = 12;
    localparam int GAIN_W         = 16;
    localparam int VALUE_W        = 22;
    localparam int TREND_W        = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int MID_CH         = 2;
    localparam int RISE_COUNT     = 3;
    localparam int FALL_COUNT     = 4;
    localparam int FILT_DIVISOR   = 5;
    localparam int FILT_ROUND     = 5;
    localparam int SCALE_SHIFT    = 6;
    localparam int DIV_RADIX_BITS = 8;

    localparam int SAMPLES_PER_FRAME_DEF = 5;
    localparam int TREND_DEPTH_DEF       = 6;

    localparam logic [VALUE_W-1:0] VALUE_MAX       = 22'h3F_FFFF;
    localparam logic [GAIN_W-1:0]  GAIN_SIDE_RST   = 16'd15172;
    localparam logic [GAIN_W-1:0]  GAIN_MIDDLE_RST = 16'd10928;

    typedef enum logic [TREND_W-1:0] {
        TR_STEADY  = 2'd0,
        TR_RISING  = 2'd1,
        TR_FALLING = 2'd2
    } t_trend;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_ch0;
        logic [SAMPLE_W-1:0] sample_ch1;
        logic [SAMPLE_W-1:0] sample_ch2;
        logic [SAMPLE_W-1:0] sample_ch3;
        logic [SAMPLE_W-1:0] sample_ch4;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] filtered_ch0;
        logic [VALUE_W-1:0] filtered_ch1;
        logic [VALUE_W-1:0] filtered_ch2;
        logic [VALUE_W-1:0] filtered_ch3;
        logic [VALUE_W-1:0] filtered_ch4;
        logic [TREND_W-1:0] trend;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE_LOAD,
        ST_SCALE_DIV,
        ST_FILT_LOAD,
        ST_FILT_DIV,
        ST_STORE,
        ST_TREND
    } t_state;

    typedef struct packed {
        logic            busy;
        logic            mul;
        logic            scale_load;
        logic            filt_load;
        logic            div_step;
        logic            store;
        logic            publish;
        logic [CH_W-1:0] ch;
    } t_cmd;

    typedef struct packed {
        logic frame_start;
    } t_status;

    function automatic int ifft_sum_width(input int spf);
        return SAMPLE_W + $clog2(spf);
    endfunction

    function automatic int ifft_div_width(input int spf);
        int w;
        w = ifft_sum_width(spf) + GAIN_W + 1 - SCALE_SHIFT;
        return (w > VALUE_W + 3) ? w : VALUE_W + 3;
    endfunction

    function automatic int ifft_div_steps(input int spf);
        return (ifft_div_width(spf) + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    endfunction

endpackage

@@ design/ifft_divider.sv @@
// Radix-256 restoring divider by a small divisor, one quotient byte per step.
// Depends on ifft_pkg; used by ifft_datapath for both the scale and the filter divisions.
module ifft_divider
    import ifft_pkg::*;
#(
    parameter int DIVW = 26,
    parameter int DVW  = 3
) (
    input  logic            i_clk,
    input  logic            i_load,
    input  logic            i_step,
    input  logic [DIVW-1:0] i_dividend,
    input  logic [DVW-1:0]  i_divisor,
    output logic [DIVW-1:0] o_quotient
);

    localparam int STEPS = (DIVW + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
    localparam int PADW  = STEPS * DIV_RADIX_BITS;

    logic [PADW-1:0] r_quo;
    logic [PADW-1:0] n_quo;
    logic [DVW-1:0]  r_rem;
    logic [DVW-1:0]  n_rem;
    logic [DVW-1:0]  r_dvs;

    always_comb begin
        logic [DVW:0] t;
        n_quo = r_quo;
        n_rem = r_rem;
        t     = '0;
        for (int i = 0; i < DIV_RADIX_BITS; i++) begin
            t     = {n_rem, n_quo[PADW-1]};
            n_quo = {n_quo[PADW-2:0], 1'b0};
            if (t >= {1'b0, r_dvs}) begin
                n_rem    = DVW'(t - {1'b0, r_dvs});
                n_quo[0] = 1'b1;
            end else begin
                n_rem = t[DVW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_quo <= PADW'(i_dividend);
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (i_step) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_quotient = r_quo[DIVW-1:0];

endmodule

@@ design/ifft_ctrl.sv @@
// Frame sequencer: walks the channels through multiply, scale division, filter division
// and store, then publishes the result. Depends on ifft_pkg.
module ifft_ctrl
    import ifft_pkg::*;
#(
    parameter int SAMPLES_PER_FRAME = SAMPLES_PER_FRAME_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int DIV_STEPS = ifft_div_steps(SAMPLES_PER_FRAME);
    localparam int STW       = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    t_state          r_state;
    t_state          n_state;
    logic [STW-1:0]  r_step;
    logic [STW-1:0]  n_step;
    logic [CH_W-1:0] r_ch;
    logic [CH_W-1:0] n_ch;
    logic            step_last;

    assign step_last = (r_step == STW'(DIV_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_ch    <= n_ch;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_ch    = r_ch;
        o_cmd   = '0;
        o_cmd.ch = r_ch;
        case (r_state)
            ST_IDLE: begin
                if (i_status.frame_start) begin
                    n_state = ST_MUL;
                    n_ch    = '0;
                end
            end
            ST_MUL: begin
                o_cmd.busy = 1'b1;
                o_cmd.mul  = 1'b1;
                n_state    = ST_SCALE_LOAD;
            end
            ST_SCALE_LOAD: begin
                o_cmd.busy       = 1'b1;
                o_cmd.scale_load = 1'b1;
                n_step           = '0;
                n_state          = ST_SCALE_DIV;
            end
            ST_SCALE_DIV: begin
                o_cmd.busy     = 1'b1;
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (step_last) begin
                    n_state = ST_FILT_LOAD;
                end
            end
            ST_FILT_LOAD: begin
                o_cmd.busy      = 1'b1;
                o_cmd.filt_load = 1'b1;
                n_step          = '0;
                n_state         = ST_FILT_DIV;
            end
            ST_FILT_DIV: begin
                o_cmd.busy     = 1'b1;
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (step_last) begin
                    n_state = ST_STORE;
                end
            end
            ST_STORE: begin
                o_cmd.busy  = 1'b1;
                o_cmd.store = 1'b1;
                if (r_ch == CH_W'(NUM_CH - 1)) begin
                    n_state = ST_TREND;
                end else begin
                    n_ch    = r_ch + 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_TREND: begin
                o_cmd.busy    = 1'b1;
                o_cmd.publish = 1'b1;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/ifft_datapath.sv @@
// Datapath: gain registers, round sums, shared multiplier and divider, filter history,
// middle-channel trend and the output register. Depends on ifft_pkg and ifft_divider.
module ifft_datapath
    import ifft_pkg::*;
#(
    parameter int SAMPLES_PER_FRAME = SAMPLES_PER_FRAME_DEF,
    parameter int TREND_DEPTH       = TREND_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [GAIN_W-1:0]    i_cfg_data,
    input  t_cmd                 i_cmd,
    output t_status              o_status
);

    localparam int SUMW  = ifft_sum_width(SAMPLES_PER_FRAME);
    localparam int DIVW  = ifft_div_width(SAMPLES_PER_FRAME);
    localparam int MAXDV = (SAMPLES_PER_FRAME > FILT_DIVISOR) ? SAMPLES_PER_FRAME : FILT_DIVISOR;
    localparam int DVW   = $clog2(MAXDV + 1);
    localparam int RCW   = (SAMPLES_PER_FRAME > 1) ? $clog2(SAMPLES_PER_FRAME) : 1;
    localparam int PW    = SUMW + GAIN_W;
    localparam int HALF  = SAMPLES_PER_FRAME * (2 ** SCALE_SHIFT) / 2;
    localparam int FSW   = VALUE_W + 4;
    localparam int CW    = $clog2(TREND_DEPTH) + 1;

    logic [GAIN_W-1:0]   r_gain [NUM_CH];
    logic [RCW-1:0]      r_round;
    logic [SUMW-1:0]     r_sum [NUM_CH];
    logic [PW-1:0]       r_prod;
    logic [VALUE_W-1:0]  r_scaled;
    logic [VALUE_W-1:0]  r_older0 [NUM_CH];
    logic [VALUE_W-1:0]  r_older1 [NUM_CH];
    logic [VALUE_W-1:0]  r_hist [TREND_DEPTH];
    logic [VALUE_W-1:0]  r_filt [NUM_CH];
    logic [TREND_W-1:0]  r_trend;
    logic                r_out_valid;

    logic [SAMPLE_W-1:0] samples [NUM_CH];
    logic                last_round;
    logic                in_xfer;
    logic [PW:0]         rounded;
    logic [FSW-1:0]      filt_num;
    logic                div_load;
    logic [DIVW-1:0]     div_dividend;
    logic [DVW-1:0]      div_divisor;
    logic [DIVW-1:0]     quotient;
    logic [VALUE_W-1:0]  q_sat;
    logic [CW-1:0]       pos_cnt;
    logic [CW-1:0]       neg_cnt;
    t_trend              trend_now;

    assign samples[0] = i_in_item.sample_ch0;
    assign samples[1] = i_in_item.sample_ch1;
    assign samples[2] = i_in_item.sample_ch2;
    assign samples[3] = i_in_item.sample_ch3;
    assign samples[4] = i_in_item.sample_ch4;

    assign last_round           = (r_round == RCW'(SAMPLES_PER_FRAME - 1));
    assign o_in_stall           = i_cmd.busy || (r_out_valid && last_round);
    assign in_xfer              = i_in_valid && !o_in_stall;
    assign o_status.frame_start = in_xfer && last_round;

    assign q_sat = (quotient > DIVW'(VALUE_MAX)) ? VALUE_MAX : quotient[VALUE_W-1:0];

    assign rounded  = {1'b0, r_prod} + (PW + 1)'(HALF);
    assign filt_num = FSW'(r_older0[i_cmd.ch]) + FSW'(r_older1[i_cmd.ch])
                    + (FSW'(q_sat) << 3) + FSW'(FILT_ROUND);

    assign div_load     = i_cmd.scale_load || i_cmd.filt_load;
    assign div_dividend = i_cmd.scale_load ? DIVW'(rounded >> SCALE_SHIFT)
                                           : DIVW'(filt_num >> 1);
    assign div_divisor  = i_cmd.scale_load ? DVW'(SAMPLES_PER_FRAME) : DVW'(FILT_DIVISOR);

    ifft_divider #(
        .DIVW (DIVW),
        .DVW  (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_load     (div_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (quotient)
    );

    always_comb begin
        pos_cnt = '0;
        neg_cnt = '0;
        for (int k = 0; k < TREND_DEPTH - 1; k++) begin
            pos_cnt = pos_cnt + CW'(r_hist[k] > r_hist[k + 1]);
            neg_cnt = neg_cnt + CW'(r_hist[k] < r_hist[k + 1]);
        end
        if (pos_cnt >= CW'(RISE_COUNT)) begin
            trend_now = TR_RISING;
        end else if (neg_cnt >= CW'(FALL_COUNT)) begin
            trend_now = TR_FALLING;
        end else begin
            trend_now = TR_STEADY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_gain[c]   <= (c == MID_CH) ? GAIN_MIDDLE_RST : GAIN_SIDE_RST;
                r_sum[c]    <= '0;
                r_older0[c] <= '0;
                r_older1[c] <= '0;
            end
            for (int k = 0; k < TREND_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en && (i_cfg_idx < CFG_IDX_W'(NUM_CH))) begin
                r_gain[i_cfg_idx] <= i_cfg_data;
            end
            if (in_xfer) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_sum[c] <= r_sum[c] + SUMW'(samples[c]);
                end
                r_round <= last_round ? '0 : r_round + 1'b1;
            end
            if (i_cmd.store) begin
                r_older0[i_cmd.ch] <= r_older1[i_cmd.ch];
                r_older1[i_cmd.ch] <= r_scaled;
                if (i_cmd.ch == CH_W'(MID_CH)) begin
                    r_hist[0] <= q_sat;
                    for (int k = 1; k < TREND_DEPTH; k++) begin
                        r_hist[k] <= r_hist[k - 1];
                    end
                end
            end
            if (i_cmd.publish) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_sum[c] <= '0;
                end
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= PW'(r_sum[i_cmd.ch]) * PW'(r_gain[i_cmd.ch]);
        end
        if (i_cmd.filt_load) begin
            r_scaled <= q_sat;
        end
        if (i_cmd.store) begin
            r_filt[i_cmd.ch] <= q_sat;
        end
        if (i_cmd.publish) begin
            r_trend <= trend_now;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_out_item.filtered_ch0 = r_filt[0];
    assign o_out_item.filtered_ch1 = r_filt[1];
    assign o_out_item.filtered_ch2 = r_filt[2];
    assign o_out_item.filtered_ch3 = r_filt[3];
    assign o_out_item.filtered_ch4 = r_filt[4];
    assign o_out_item.trend        = r_trend;

endmodule

@@ design/inductor_frame_filter_trend_core.sv @@
// Top level of the inductor frame filter with middle-channel trend detection.
// Depends on ifft_pkg, ifft_ctrl and ifft_datapath.
//
//   Channel   Direction  Handshake                  Payload
//   in        to core    i_in_valid / o_in_stall    i_in_item  (t_in_item)
//   out       from core  o_out_valid / i_out_stall  o_out_item (t_out_item)
//   cfg       to core    i_cfg_wr_en                i_cfg_idx, i_cfg_data
//
// A round that does not close a frame only adds its samples to the round sums.
// A closing round starts a frame computation: per channel multiply, scale division, filter
// division and store, then publish; each division loads and runs S = ceil(W / 8) byte steps
// of the shared divider (W = 26 by default). The input is stalled during that computation,
// and a closing round is also stalled while the previous result is not yet transferred.
// Reset is synchronous; gains return to their default values and all history clears.
module inductor_frame_filter_trend_core
    import ifft_pkg::*;
#(
    parameter int SAMPLES_PER_FRAME = SAMPLES_PER_FRAME_DEF,
    parameter int TREND_DEPTH       = TREND_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [GAIN_W-1:0]    i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    ifft_ctrl #(
        .SAMPLES_PER_FRAME (SAMPLES_PER_FRAME)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    ifft_datapath #(
        .SAMPLES_PER_FRAME (SAMPLES_PER_FRAME),
        .TREND_DEPTH       (TREND_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

@@ design/ifft_checker.sv @@
// Port-level checker for the inductor frame filter, bound to the top level.
// Depends on ifft_pkg and inductor_frame_filter_trend_core_assert.svh.
`include "inductor_frame_filter_trend_core_assert.svh"

module ifft_checker
    import ifft_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item
);

    `IFFT_ASSERT_NEXT(a_out_valid_holds, o_out_valid && i_out_stall, o_out_valid)
    `IFFT_ASSERT_NEXT(a_out_item_holds, o_out_valid && i_out_stall, $stable(o_out_item))
    `IFFT_ASSERT_NEXT(a_out_single_transfer, o_out_valid && !i_out_stall, !o_out_valid)
    `IFFT_ASSERT_NOW(a_out_after_busy, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind inductor_frame_filter_trend_core ifft_checker u_ifft_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

@@ dv/tb_inductor_frame_filter_trend_core.sv @@
// Self-checking testbench for inductor_frame_filter_trend_core: sample rounds, gain writes,
// filtered frames and the middle-channel trend, checked against an in-bench predictor.
// Depends on ifft_pkg and the core RTL only.
module tb_inductor_frame_filter_trend_core;
    import ifft_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_LEFT_DIAGONAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_LEFT_LEVEL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_MIDDLE         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_RIGHT_LEVEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_RIGHT_DIAGONAL = 3'd4;

    localparam int MAX_WAIT         = 8;
    localparam int HOLD_CYCLES      = 400;
    localparam int SETTLE_CYCLES    = 80;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int FRAMES_PER_PHASE = 18;
    localparam int SETTINGS_USED    = 7;
    localparam int SAMPLE_TOP       = (1 << SAMPLE_W) - 1;
    localparam int WEIGHT_TOTAL     = 10;
    localparam int WEIGHT_NEWEST    = 8;
    localparam int GAIN_TOP         = (1 << GAIN_W) - 1;
    localparam longint unsigned SCALE_DEN = SAMPLES_PER_FRAME_DEF * (1 << SCALE_SHIFT);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_W'(SAMPLE_TOP);
    localparam logic [GAIN_W-1:0]   GAIN_FULL  = GAIN_W'(GAIN_TOP);

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [GAIN_W-1:0]    i_cfg_data  = '0;

    inductor_frame_filter_trend_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state.
    logic [GAIN_W-1:0]  gain_model [NUM_CH];
    int unsigned        rounds_in_frame;
    logic [14:0]        frame_sums [NUM_CH];
    logic [VALUE_W-1:0] scaled_hist [NUM_CH][2];
    logic [VALUE_W-1:0] middle_hist [TREND_DEPTH_DEF];
    t_out_item          frames_due [$];
    t_in_item           rounds_pending [$];

    logic      in_taken  = 1'b0;
    logic      out_taken = 1'b0;
    int        round_gap = 0;
    bit        round_burst = 1'b0;
    int        result_wait = 0;
    bit        result_burst = 1'b0;
    int        hold_requests = 0;
    int        holds_done = 0;
    int        hold_left = 0;
    int        cycle_count = 0;
    int        errors = 0;
    int        rounds_taken = 0;
    int        frames_checked = 0;
    int        trend_seen [3] = '{0, 0, 0};
    int        ch_level [NUM_CH];
    int        ch_dir [NUM_CH];
    t_out_item frame_want;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void absorb_round(input t_in_item r);
        logic [SAMPLE_W-1:0] smp [NUM_CH];
        logic [VALUE_W-1:0]  filt [NUM_CH];
        logic [VALUE_W-1:0]  scaled;
        longint unsigned     acc;
        int                  c, k, rises, falls;
        t_out_item           res;
        smp[0] = r.sample_ch0;
        smp[1] = r.sample_ch1;
        smp[2] = r.sample_ch2;
        smp[3] = r.sample_ch3;
        smp[4] = r.sample_ch4;
        for (c = 0; c < NUM_CH; c++) begin
            frame_sums[c] = frame_sums[c] + 15'(smp[c]);
        end
        rounds_in_frame++;
        if (rounds_in_frame < SAMPLES_PER_FRAME_DEF) begin
            return;
        end
        for (c = 0; c < NUM_CH; c++) begin
            acc = (64'(frame_sums[c]) * 64'(gain_model[c]) + SCALE_DEN / 2) / SCALE_DEN;
            scaled = (acc > VALUE_MAX) ? VALUE_MAX : acc[VALUE_W-1:0];
            acc = (64'(scaled_hist[c][0]) + 64'(scaled_hist[c][1])
                   + WEIGHT_NEWEST * 64'(scaled) + FILT_ROUND) / WEIGHT_TOTAL;
            filt[c] = (acc > VALUE_MAX) ? VALUE_MAX : acc[VALUE_W-1:0];
            scaled_hist[c][0] = scaled_hist[c][1];
            scaled_hist[c][1] = scaled;
            frame_sums[c] = '0;
        end
        for (k = TREND_DEPTH_DEF - 1; k > 0; k--) begin
            middle_hist[k] = middle_hist[k-1];
        end
        middle_hist[0] = filt[MID_CH];
        rises = 0;
        falls = 0;
        for (k = 0; k < TREND_DEPTH_DEF - 1; k++) begin
            if (middle_hist[k] > middle_hist[k+1]) begin
                rises++;
            end else if (middle_hist[k] < middle_hist[k+1]) begin
                falls++;
            end
        end
        res.filtered_ch0 = filt[0];
        res.filtered_ch1 = filt[1];
        res.filtered_ch2 = filt[2];
        res.filtered_ch3 = filt[3];
        res.filtered_ch4 = filt[4];
        if (rises >= RISE_COUNT) begin
            res.trend = TR_RISING;
        end else if (falls >= FALL_COUNT) begin
            res.trend = TR_FALLING;
        end else begin
            res.trend = TR_STEADY;
        end
        frames_due.push_back(res);
        rounds_in_frame = 0;
    endfunction

    function automatic void check_field(input string name, input logic [VALUE_W-1:0] want,
                                        input logic [VALUE_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
        if (v < 0) begin
            return '0;
        end
        if (v > SAMPLE_TOP) begin
            return SAMPLE_MAX;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic t_in_item uniform_round(input logic [SAMPLE_W-1:0] v);
        t_in_item r;
        r = '{v, v, v, v, v};
        return r;
    endfunction

    // Result checking happens before the new round is absorbed.
    always @(posedge i_clk) begin
        in_taken  <= i_rst_n && i_in_valid && (o_in_stall === 1'b0);
        out_taken <= i_rst_n && (o_out_valid === 1'b1) && !i_out_stall;
        if (i_rst_n && (o_out_valid === 1'b1) && !i_out_stall) begin
            if (frames_due.size() == 0) begin
                $display("%0t: result with no frame expected, expected none, actual %h",
                         $time, o_out_item);
                errors++;
            end else begin
                frame_want = frames_due.pop_front();
                check_field("filtered_ch0", frame_want.filtered_ch0, o_out_item.filtered_ch0);
                check_field("filtered_ch1", frame_want.filtered_ch1, o_out_item.filtered_ch1);
                check_field("filtered_ch2", frame_want.filtered_ch2, o_out_item.filtered_ch2);
                check_field("filtered_ch3", frame_want.filtered_ch3, o_out_item.filtered_ch3);
                check_field("filtered_ch4", frame_want.filtered_ch4, o_out_item.filtered_ch4);
                check_field("trend", VALUE_W'(frame_want.trend), VALUE_W'(o_out_item.trend));
                trend_seen[int'(frame_want.trend)]++;
                frames_checked++;
            end
        end
        if (i_rst_n && i_in_valid && (o_in_stall === 1'b0)) begin
            absorb_round(i_in_item);
            rounds_taken++;
        end
    end

    always @(negedge i_clk) begin : drive_rounds
        logic     next_valid;
        t_in_item next_item;
        next_valid = i_in_valid && !in_taken;
        next_item  = i_in_item;
        if (i_rst_n && !next_valid) begin
            if (round_gap > 0) begin
                round_gap--;
            end else if (rounds_pending.size() > 0) begin
                next_item  = rounds_pending.pop_front();
                next_valid = 1'b1;
                if ($urandom_range(0, 39) == 0) begin
                    round_burst = !round_burst;
                end
                round_gap = round_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end
        end
        i_in_valid <= next_valid;
        i_in_item  <= next_item;
    end

    always @(negedge i_clk) begin : drive_stall
        if (out_taken) begin
            if ($urandom_range(0, 39) == 0) begin
                result_burst = !result_burst;
            end
            result_wait = result_burst ? 0 : $urandom_range(0, MAX_WAIT);
        end else if (result_wait > 0) begin
            result_wait--;
        end
        i_out_stall <= (hold_left > 0) || (result_wait > 0);
    end

    // Long receiver hold-off so that the core fills up and stalls its input.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_requests != holds_done) begin
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [GAIN_W-1:0] random_gain();
        return GAIN_W'($urandom_range(0, GAIN_TOP));
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= value;
        if (idx < NUM_CH) begin
            gain_model[idx] = value;
        end
    endtask

    task automatic program_gains(input logic [GAIN_W-1:0] left_diag, left_lvl, mid,
                                 right_lvl, right_diag, input bit stray);
        int n;
        write_reg(REG_GAIN_LEFT_DIAGONAL, left_diag);
        write_reg(REG_GAIN_LEFT_LEVEL, left_lvl);
        write_reg(REG_GAIN_MIDDLE, mid);
        write_reg(REG_GAIN_RIGHT_LEVEL, right_lvl);
        write_reg(REG_GAIN_RIGHT_DIAGONAL, right_diag);
        if (stray) begin
            for (n = NUM_CH; n < (1 << CFG_IDX_W); n++) begin
                write_reg(CFG_IDX_W'(n), random_gain());
            end
        end
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Most frames follow drifting per-channel levels so that the trend moves;
    // the rest are wild rounds with frequent extremes.
    task automatic queue_frames(input int n_frames);
        int                  f, r, c, step;
        bit                  wild;
        logic [SAMPLE_W-1:0] smp [NUM_CH];
        t_in_item            item;
        for (f = 0; f < n_frames; f++) begin
            for (c = 0; c < NUM_CH; c++) begin
                step = $urandom_range(0, 400);
                ch_level[c] = int'(clamp_sample(ch_dir[c] > 0 ? ch_level[c] + step
                                                              : ch_level[c] - step));
                if ($urandom_range(0, 3) == 0) begin
                    ch_dir[c] = -ch_dir[c];
                end
            end
            wild = ($urandom_range(0, 9) < 3);
            for (r = 0; r < SAMPLES_PER_FRAME_DEF; r++) begin
                for (c = 0; c < NUM_CH; c++) begin
                    if (!wild) begin
                        smp[c] = clamp_sample(ch_level[c] + int'($urandom_range(0, 64)) - 32);
                    end else begin
                        case ($urandom_range(0, 4))
                            0: smp[c] = '0;
                            1: smp[c] = SAMPLE_MAX;
                            default: smp[c] = SAMPLE_W'($urandom_range(0, SAMPLE_TOP));
                        endcase
                    end
                end
                item = '{smp[0], smp[1], smp[2], smp[3], smp[4]};
                rounds_pending.push_back(item);
            end
        end
    endtask

    task automatic drain;
        while (rounds_pending.size() > 0 || i_in_valid || frames_due.size() > 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int       c, k;
        t_in_item mixed;
        for (c = 0; c < NUM_CH; c++) begin
            gain_model[c] = GAIN_SIDE_RST;
            frame_sums[c] = '0;
            scaled_hist[c][0] = '0;
            scaled_hist[c][1] = '0;
            ch_level[c] = $urandom_range(0, SAMPLE_TOP);
            ch_dir[c] = ($urandom_range(0, 1) == 0) ? 1 : -1;
        end
        gain_model[MID_CH] = GAIN_MIDDLE_RST;
        for (k = 0; k < TREND_DEPTH_DEF; k++) begin
            middle_hist[k] = '0;
        end
        rounds_in_frame = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames at reset gains: zero, full scale, alternating bits, mixed extremes.
        mixed = '{12'h000, SAMPLE_MAX, 12'h800, 12'h001, SAMPLE_MAX - 1'b1};
        for (k = 0; k < SAMPLES_PER_FRAME_DEF; k++) begin
            rounds_pending.push_back(uniform_round('0));
        end
        for (k = 0; k < SAMPLES_PER_FRAME_DEF; k++) begin
            rounds_pending.push_back(uniform_round(SAMPLE_MAX));
        end
        for (k = 0; k < SAMPLES_PER_FRAME_DEF; k++) begin
            rounds_pending.push_back(uniform_round(k[0] ? 12'h555 : 12'hAAA));
        end
        for (k = 0; k < SAMPLES_PER_FRAME_DEF; k++) begin
            rounds_pending.push_back(mixed);
        end
        for (k = 0; k < SAMPLES_PER_FRAME_DEF; k++) begin
            rounds_pending.push_back(uniform_round(SAMPLE_MAX));
        end
        drain();

        program_gains(GAIN_FULL, GAIN_FULL, GAIN_FULL, GAIN_FULL, GAIN_FULL, 1'b0);
        queue_frames(FRAMES_PER_PHASE);
        drain();

        program_gains('0, '0, '0, '0, '0, 1'b1);
        queue_frames(FRAMES_PER_PHASE);
        drain();

        program_gains(random_gain(), random_gain(), random_gain(), random_gain(),
                      random_gain(), 1'b1);
        queue_frames(FRAMES_PER_PHASE);
        drain();

        program_gains(16'd1, 16'd16384, GAIN_FULL, 16'd0, 16'd32768, 1'b0);
        queue_frames(FRAMES_PER_PHASE);
        drain();

        program_gains(random_gain(), random_gain(), random_gain(), random_gain(),
                      random_gain(), 1'b1);
        hold_requests++;
        queue_frames(FRAMES_PER_PHASE);
        drain();

        program_gains(GAIN_SIDE_RST, GAIN_SIDE_RST, GAIN_MIDDLE_RST, GAIN_SIDE_RST,
                      GAIN_SIDE_RST, 1'b1);
        queue_frames(FRAMES_PER_PHASE);
        drain();

        $display("Checked %0d frames from %0d sample rounds across %0d gain settings.",
                 frames_checked, rounds_taken, SETTINGS_USED);
        $display("Trend results: %0d steady, %0d rising, %0d falling.",
                 trend_seen[TR_STEADY], trend_seen[TR_RISING], trend_seen[TR_FALLING]);
        if (errors == 0 && frames_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ inductor_frame_filter_trend_core.f @@
+incdir+design
design/ifft_pkg.sv
design/ifft_divider.sv
design/ifft_ctrl.sv
design/ifft_datapath.sv
design/inductor_frame_filter_trend_core.sv
design/ifft_checker.sv
dv/tb_inductor_frame_filter_trend_core.sv
